### rtl/rcd_pkg.sv
package rcd_pkg;

  // Offsets applied while decoding.
  localparam int unsigned YearBase       = 2000;
  localparam int unsigned PmHourOffset   = 12;
  localparam int unsigned MinutesPerHour = 60;
  localparam int unsigned DaysPerWeek    = 7;

  // A weekday register code of seven is folded onto Sunday (zero).
  localparam logic [2:0] WeekdaySundayAlias = 3'd7;
  localparam logic [2:0] WeekdaySunday      = 3'd0;

  // Division by seven as a multiply by a reciprocal and a shift.
  // The product is exact for every dividend below 512.
  localparam int unsigned Recip7      = 293;
  localparam int unsigned Recip7Shift = 11;

  // Decodes one packed BCD byte. A nibble above nine keeps its binary weight.
  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'b0000, b[7:4]};
    return (tens << 3) + (tens << 1) + {4'b0000, b[3:0]};
  endfunction

  // Days in the year before the first of the given month. A month code
  // outside January to December gives no offset.
  function automatic logic [8:0] days_before_month(input logic [4:0] month);
    logic [8:0] days;
    unique case (month)
      5'd1:    days = 9'd0;
      5'd2:    days = 9'd31;
      5'd3:    days = 9'd59;
      5'd4:    days = 9'd90;
      5'd5:    days = 9'd120;
      5'd6:    days = 9'd151;
      5'd7:    days = 9'd181;
      5'd8:    days = 9'd212;
      5'd9:    days = 9'd243;
      5'd10:   days = 9'd273;
      5'd11:   days = 9'd304;
      5'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

### rtl/rtc_calendar_decode_core.sv
// Calendar decoder for a real-time clock. Each item carries one packed BCD
// time word and one packed BCD date word; the block returns the hour (with
// twelve added when the PM flag is set), minute, second, day, month, the
// four-digit year (2000 plus the BCD year), the weekday (register code seven
// reads as Sunday, zero), the minute of the day, the day of the year (with a
// leap day after February in years divisible by four) and the week of the
// year. BCD digits are not checked: a nibble above nine keeps its binary
// weight and each result wraps to its port width. The block has an input
// register and a result register with the decode logic between them. An
// item's result is registered as the item moves from the input register
// into the result register, which waits while an earlier result is held
// at the output. A new item can be taken in every cycle unless both
// registers are full and the output is held. The input register takes a
// new item whenever it is empty or its contents move on into the result
// register in the same cycle, so a result held at the output does not stall
// the input until both registers are full. No state is kept between items.
module rtc_calendar_decode_core
  import rcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [22:0] time_word_i,
  input  logic [23:0] date_word_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [4:0]  day_o,
  output logic [3:0]  month_o,
  output logic [11:0] year_o,
  output logic [2:0]  weekday_o,
  output logic [10:0] minute_of_day_o,
  output logic [8:0]  day_of_year_o,
  output logic [5:0]  week_of_year_o
);

  // Input register.
  logic        in_valid_q, in_valid_d;
  logic [22:0] time_word_q;
  logic [23:0] date_word_q;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [11:0] year_q;
  logic [2:0]  weekday_q;
  logic [10:0] minute_of_day_q;
  logic [8:0]  day_of_year_q;
  logic [5:0]  week_of_year_q;

  logic in_load;
  logic out_load;

  // Full-width decoded values; the ports take their low bits.
  logic [7:0]  hour_bcd, minute_bcd, second_bcd, day_bcd, month_bcd, year_bcd;
  logic [5:0]  hour_full;    // at most 57
  logic [6:0]  minute_full;  // at most 85
  logic [6:0]  second_full;
  logic [5:0]  day_full;     // at most 45
  logic [4:0]  month_full;   // at most 25
  logic [11:0] year_full;    // at most 2165
  logic [2:0]  weekday;
  logic [11:0] minute_of_day_full;
  logic        leap_day;
  logic [8:0]  day_of_year_full;  // at most 380
  logic [8:0]  week_num;          // day of year plus seven less weekday
  logic [17:0] week_prod;
  logic [6:0]  week_quot;
  logic [5:0]  week_of_year;

  // Handshake. The result register loads when it is empty or being emptied;
  // the input register loads when it is empty or handing over this cycle.
  assign out_load   = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || out_load;
  assign in_load    = in_valid_i && in_ready_o;

  // When the input register is not ready it is holding an item.
  assign in_valid_d  = in_ready_o ? in_valid_i : 1'b1;
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      time_word_q <= time_word_i;
      date_word_q <= date_word_i;
    end
  end

  // Field decode.
  always_comb begin
    hour_bcd   = bcd_decode({2'b00, time_word_q[21:16]});
    minute_bcd = bcd_decode({1'b0, time_word_q[14:8]});
    second_bcd = bcd_decode({1'b0, time_word_q[6:0]});
    day_bcd    = bcd_decode({2'b00, date_word_q[5:0]});
    month_bcd  = bcd_decode({3'b000, date_word_q[12:8]});
    year_bcd   = bcd_decode(date_word_q[23:16]);

    hour_full   = hour_bcd[5:0] + (time_word_q[22] ? 6'(PmHourOffset) : 6'd0);
    minute_full = minute_bcd[6:0];
    second_full = second_bcd[6:0];
    day_full    = day_bcd[5:0];
    month_full  = month_bcd[4:0];
    year_full   = 12'(YearBase) + {4'b0000, year_bcd};

    weekday = (date_word_q[15:13] == WeekdaySundayAlias) ? WeekdaySunday
                                                         : date_word_q[15:13];
  end

  // Derived values.
  always_comb begin
    minute_of_day_full = {6'b000000, hour_full} * 12'(MinutesPerHour)
                       + {5'b00000, minute_full};

    // The base year is a multiple of four, so only the BCD year matters here.
    leap_day = (year_full[1:0] == 2'b00) && (month_full > 5'd2);
    day_of_year_full = days_before_month(month_full) + {3'b000, day_full}
                     + {8'h00, leap_day};

    // Never negative: the weekday is at most six.
    week_num     = day_of_year_full + 9'(DaysPerWeek) - {6'b000000, weekday};
    week_prod    = {9'h000, week_num} * 18'(Recip7);
    week_quot    = week_prod[17:Recip7Shift];
    week_of_year = 6'(week_quot + 7'd1);
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hour_q          <= hour_full[4:0];
      minute_q        <= minute_full[5:0];
      second_q        <= second_full[5:0];
      day_q           <= day_full[4:0];
      month_q         <= month_full[3:0];
      year_q          <= year_full;
      weekday_q       <= weekday;
      minute_of_day_q <= minute_of_day_full[10:0];
      day_of_year_q   <= day_of_year_full;
      week_of_year_q  <= week_of_year;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hour_o          = hour_q;
  assign minute_o        = minute_q;
  assign second_o        = second_q;
  assign day_o           = day_q;
  assign month_o         = month_q;
  assign year_o          = year_q;
  assign weekday_o       = weekday_q;
  assign minute_of_day_o = minute_of_day_q;
  assign day_of_year_o   = day_of_year_q;
  assign week_of_year_o  = week_of_year_q;

  // The input side only stalls when both registers hold an item and the
  // output is not being drained.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while a register stage was free");

  // An item handed from the input register shows up at the output next cycle.
  a_handover_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("item lost between input and result registers");

  // The week number is one plus a non-negative quotient and never wraps.
  a_week_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (week_of_year_o != 6'd0))
    else $error("week of year is zero");

  // The year is always the base year plus at most a two-digit BCD value.
  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (year_o >= 12'(YearBase) && year_o <= 12'd2165))
    else $error("decoded year out of range");

endmodule

### sim/tb_rtc_calendar_decode_core.sv
// Self-checking testbench for rtc_calendar_decode_core.
module tb_rtc_calendar_decode_core;

  // Weekday register code that reads back as Sunday.
  localparam logic [2:0] SundayAlias = 3'd7;
  localparam int unsigned CenturyBase = 2000;
  localparam int unsigned PmOffset = 12;
  // Cycles allowed after the last result before the run ends.
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned ItemsPerPhase = 175;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
    logic [10:0] minute_of_day;
    logic [8:0]  day_of_year;
    logic [5:0]  week_of_year;
  } calendar_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [22:0] time_word_i;
  logic [23:0] date_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;
  logic [4:0]  day_o;
  logic [3:0]  month_o;
  logic [11:0] year_o;
  logic [2:0]  weekday_o;
  logic [10:0] minute_of_day_o;
  logic [8:0]  day_of_year_o;
  logic [5:0]  week_of_year_o;

  // Decoded calendars still owed by the block, oldest first.
  calendar_t   pending_calendars[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  rtc_calendar_decode_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .time_word_i    (time_word_i),
    .date_word_i    (date_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o),
    .day_o          (day_o),
    .month_o        (month_o),
    .year_o         (year_o),
    .weekday_o      (weekday_o),
    .minute_of_day_o(minute_of_day_o),
    .day_of_year_o  (day_of_year_o),
    .week_of_year_o (week_of_year_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Weighs each nibble by its binary value, so digits above nine are not
  // rejected but simply counted as they stand.
  function automatic int unsigned bcd_value(input logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic logic [7:0] to_bcd(input int unsigned v);
    logic [3:0] tens;
    logic [3:0] units;
    tens  = 4'(v / 10);
    units = 4'(v % 10);
    return {tens, units};
  endfunction

  // Days elapsed before the first of a month; anything that is not a real
  // month contributes nothing.
  function automatic int unsigned days_ahead_of(input int unsigned mo);
    case (mo)
      1:       return 0;
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      12:      return 334;
      default: return 0;
    endcase
  endfunction

  // Works out the full calendar that the block should return for one item.
  // Everything is computed at full width and only cut to the port widths at
  // the end, which is where the wrapping of out-of-range digits shows up.
  function automatic calendar_t decode_calendar(input logic [22:0] tw,
                                                input logic [23:0] dw);
    calendar_t   c;
    int unsigned hr;
    int unsigned mi;
    int unsigned se;
    int unsigned dy;
    int unsigned mo;
    int unsigned yr;
    int unsigned wd;
    int unsigned mod;
    int unsigned doy;
    int unsigned woy;
    hr = bcd_value({2'b00, tw[21:16]});
    if (tw[22]) begin
      hr += PmOffset;
    end
    mi = bcd_value({1'b0, tw[14:8]});
    se = bcd_value({1'b0, tw[6:0]});
    dy = bcd_value({2'b00, dw[5:0]});
    mo = bcd_value({3'b000, dw[12:8]});
    yr = bcd_value(dw[23:16]) + CenturyBase;
    wd = (dw[15:13] == SundayAlias) ? 0 : int'(dw[15:13]);
    mod = hr * 60 + mi;
    doy = days_ahead_of(mo) + dy;
    // The leap day is added for any month code above February, even one that
    // is not a real month.
    if ((yr % 4) == 0 && mo > 2) begin
      doy += 1;
    end
    woy = (doy + 7 - wd) / 7 + 1;
    c.hour          = hr[4:0];
    c.minute        = mi[5:0];
    c.second        = se[5:0];
    c.day           = dy[4:0];
    c.month         = mo[3:0];
    c.year          = yr[11:0];
    c.weekday       = wd[2:0];
    c.minute_of_day = mod[10:0];
    c.day_of_year   = doy[8:0];
    c.week_of_year  = woy[5:0];
    return c;
  endfunction

  function automatic logic [22:0] pack_time(input logic pm, input logic [7:0] hr,
                                            input logic [7:0] mi, input logic [7:0] se);
    return {pm, hr[5:0], 1'b0, mi[6:0], 1'b0, se[6:0]};
  endfunction

  function automatic logic [23:0] pack_date(input logic [7:0] yr, input logic [2:0] wd,
                                            input logic [7:0] mo, input logic [7:0] dy);
    return {yr, wd, mo[4:0], 2'b00, dy[5:0]};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  // Presents one item from a falling edge and holds it until the block takes
  // it. Valid is left high on return so that the next item can follow in the
  // very next cycle without a bubble.
  task automatic send_item(input logic [22:0] tw, input logic [23:0] dw);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    time_word_i = tw;
    date_word_i = dw;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    pending_calendars.push_back(decode_calendar(tw, dw));
  endtask

  // The receiver holds off at random, redrawn every cycle.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Every result taken from the block is compared against the oldest
  // outstanding prediction.
  always @(posedge clk_i) begin
    calendar_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_calendars.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
      end else begin
        want = pending_calendars.pop_front();
        check_field("hour", 32'(hour_o), 32'(want.hour));
        check_field("minute", 32'(minute_o), 32'(want.minute));
        check_field("second", 32'(second_o), 32'(want.second));
        check_field("day", 32'(day_o), 32'(want.day));
        check_field("month", 32'(month_o), 32'(want.month));
        check_field("year", 32'(year_o), 32'(want.year));
        check_field("weekday", 32'(weekday_o), 32'(want.weekday));
        check_field("minute_of_day", 32'(minute_of_day_o), 32'(want.minute_of_day));
        check_field("day_of_year", 32'(day_of_year_o), 32'(want.day_of_year));
        check_field("week_of_year", 32'(week_of_year_o), 32'(want.week_of_year));
      end
      results_seen++;
    end
  end

  // Time fields at their limits, the afternoon flag, digits above nine and
  // words with every bit set or clear.
  task automatic test_time_fields();
    logic [23:0] dw;
    dw = pack_date(8'h24, 3'd1, 8'h01, 8'h01);
    send_item(pack_time(1'b0, 8'h00, 8'h00, 8'h00), dw);
    send_item(pack_time(1'b0, 8'h23, 8'h59, 8'h59), dw);
    // Noon flagged as afternoon comes out as hour 24.
    send_item(pack_time(1'b1, 8'h12, 8'h00, 8'h00), dw);
    // Units digits above nine, then the afternoon flag on top: the hour wraps.
    send_item(pack_time(1'b1, 8'h3F, 8'h7F, 8'h7F), dw);
    send_item(23'h7FFFFF, 24'hFFFFFF);
    send_item(23'h000000, 24'h000000);
  endtask

  // One date in every month, alternating leap and ordinary years, with the
  // weekday code running through all eight values.
  task automatic test_month_table();
    for (int unsigned m = 1; m <= 12; m++) begin
      send_item(pack_time(1'b0, 8'h08, 8'h15, 8'h30),
                pack_date((m % 2) ? 8'h23 : 8'h24, 3'(m % 8), to_bcd(m), 8'h15));
    end
  endtask

  // Leap-year boundaries, the last day of the year, the Sunday alias and
  // month codes that are not real months.
  task automatic test_special_dates();
    logic [22:0] tw;
    tw = pack_time(1'b0, 8'h10, 8'h20, 8'h30);
    send_item(tw, pack_date(8'h24, 3'd4, 8'h02, 8'h29));
    send_item(tw, pack_date(8'h24, 3'd5, 8'h03, 8'h01));
    send_item(tw, pack_date(8'h24, 3'd2, 8'h12, 8'h31));
    send_item(tw, pack_date(8'h99, SundayAlias, 8'h12, 8'h31));
    // Month zero gets neither an offset nor a leap day.
    send_item(tw, pack_date(8'h00, 3'd6, 8'h00, 8'h31));
    // Month thirteen gets no offset but does get the leap day.
    send_item(tw, pack_date(8'h24, 3'd3, 8'h13, 8'h10));
    // A hexadecimal month digit lands on October by its binary weight.
    send_item(tw, pack_date(8'h00, 3'd0, 8'h0A, 8'h01));
    send_item(tw, pack_date(8'hFF, 3'd1, 8'h1F, 8'h3F));
  endtask

  // Mostly genuine times and dates with random content, the rest raw words.
  task automatic run_random(input int unsigned n);
    logic [31:0] raw_t;
    logic [31:0] raw_d;
    logic        pm;
    for (int unsigned i = 0; i < n; i++) begin
      raw_t = $urandom;
      raw_d = $urandom;
      if ($urandom_range(99) < 75) begin
        pm = 1'($urandom_range(1));
        send_item(pack_time(pm, to_bcd($urandom_range(pm ? 11 : 23)),
                            to_bcd($urandom_range(59)), to_bcd($urandom_range(59))),
                  pack_date(to_bcd($urandom_range(99)), 3'($urandom_range(7)),
                            to_bcd($urandom_range(1, 12)), to_bcd($urandom_range(1, 31))));
      end else begin
        send_item(raw_t[22:0], raw_d[23:0]);
      end
    end
  endtask

  task automatic test_random_back_to_back();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random(ItemsPerPhase);
  endtask

  task automatic test_random_sender_gaps();
    sender_idle_pct    = 79;
    receiver_stall_pct = 0;
    run_random(ItemsPerPhase);
  endtask

  task automatic test_random_receiver_stalls();
    sender_idle_pct    = 0;
    receiver_stall_pct = 79;
    run_random(ItemsPerPhase);
  endtask

  task automatic test_random_both_idle();
    sender_idle_pct    = 35;
    receiver_stall_pct = 35;
    run_random(ItemsPerPhase);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    time_word_i = '0;
    date_word_i = '0;
    out_ready_i = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_time_fields();
    test_month_table();
    test_special_dates();
    test_random_back_to_back();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_calendars.size() != 0) begin
      @(posedge clk_i);
    end
    // Any stray result shortly after the last one is still caught.
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("rtc_calendar_decode_core: match");
    end else begin
      $display("rtc_calendar_decode_core: mismatch");
    end
    $finish;
  end

  // Far beyond the slowest correct run, so only a hang ends up here.
  initial begin
    #2000000;
    $display("rtc_calendar_decode_core: mismatch");
    $finish;
  end

endmodule
